### hw/rtl/r2fft_pkg.sv
package r2fft_pkg;

  localparam int POINTS_DEF      = 64;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int OUT_BITS        = 23;
  localparam int TW_BITS         = 17;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // Sine of a Q30 angle in [0, pi/2], Taylor series to order 15, rounded to Q15.
  function automatic logic [TW_BITS-1:0] sin_q15(input longint unsigned th);
    longint unsigned x2;
    longint unsigned term;
    longint          ssum;
    int              i;
    x2   = (th * th + (64'd1 << 29)) >> 30;
    term = th;
    ssum = longint'(th);
    for (i = 1; i <= 7; i++) begin
      term = ((term * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
      if (i % 2 == 1) begin
        ssum = ssum - longint'(term);
      end else begin
        ssum = ssum + longint'(term);
      end
    end
    if (ssum < 0) begin
      ssum = 0;
    end
    return TW_BITS'((ssum + 64'sd16384) >>> 15);
  endfunction

  // Cosine of a Q30 angle in [0, pi/2], Taylor series to order 14, rounded to Q15.
  function automatic logic [TW_BITS-1:0] cos_q15(input longint unsigned th);
    longint unsigned x2;
    longint unsigned term;
    longint          csum;
    int              i;
    x2   = (th * th + (64'd1 << 29)) >> 30;
    term = 64'd1 << 30;
    csum = longint'(term);
    for (i = 1; i <= 7; i++) begin
      term = ((term * x2) >> 30) / 64'((2 * i - 1) * (2 * i));
      if (i % 2 == 1) begin
        csum = csum - longint'(term);
      end else begin
        csum = csum + longint'(term);
      end
    end
    if (csum < 0) begin
      csum = 0;
    end
    return TW_BITS'((csum + 64'sd16384) >>> 15);
  endfunction

endpackage

### hw/rtl/radix2_fft_frame_top.sv
// Frame-based radix-2 decimation-in-time FFT.
// Samples enter in natural order: a request is taken when start is high and
// busy is low, and each one is written straight into the frame store. The
// sample that completes a frame of 2^size_log2 points (size_log2 capped at
// log2(POINTS)) raises busy for the whole transform. The frame is
// bit-reverse reordered in place, then every stage runs its n/2 butterflies
// on one shared multiplier: the four partial products of the complex
// multiply go through it one after another, then the two results are written
// back over the single write port of the frame store. Bins then leave in
// natural order, each on result_valid_o for exactly one cycle, the final one
// with last_result_o; busy falls together with the last strobe. The receiver
// cannot hold results off. Configuration (size_log2 at index 0, inverse_mode
// at index 1) is ready only while busy is low, so it is written between
// frames or between samples. Reset clears the load count and returns
// size_log2 to log2(POINTS), capped at 6, and inverse_mode to forward; the
// frame store is not cleared, since loading writes every entry before it is
// read.
module radix2_fft_frame_top
  import r2fft_pkg::*;
#(
  parameter int POINTS      = POINTS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [SAMPLE_BITS-1:0] sample_re_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_im_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [2:0]                    cfg_data_i,
  output logic                          result_valid_o,
  output logic signed [OUT_BITS-1:0]    result_re_o,
  output logic signed [OUT_BITS-1:0]    result_im_o,
  output logic                          last_result_o
);

  localparam int LG  = $clog2(POINTS);
  localparam int AW  = LG;
  localparam int SW  = $clog2(LG + 1);
  localparam int DW  = SAMPLE_BITS + LG + 2;
  localparam int PW  = DW + TW_BITS;
  localparam int EW  = ((DW + 1) > OUT_BITS ? (DW + 1) : OUT_BITS) + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_REV  = 2'd1;
  localparam logic [1:0] S_BFLY = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  localparam logic CFG_SIZE = 1'b0;
  localparam logic CFG_INV  = 1'b1;

  localparam logic signed [PW:0]   RND_HALF = (PW + 1)'(16384);
  localparam logic signed [EW-1:0] OUT_MAX  = (EW'(1) <<< (OUT_BITS - 1)) - EW'(1);
  localparam logic signed [EW-1:0] OUT_MIN  = -(EW'(1) <<< (OUT_BITS - 1));

  // Twiddle table indexed by k * POINTS / len.
  logic signed [TW_BITS-1:0] tw_cos [POINTS];
  logic signed [TW_BITS-1:0] tw_sin [POINTS];

  for (genvar g = 0; g < POINTS; g++) begin : g_tw
    localparam int              M  = (4 * g > POINTS) ? (POINTS / 2 - g) : g;
    localparam longint unsigned TH = (PI_Q30 * 2 * M + POINTS / 2) / POINTS;
    if (2 * g >= POINTS) begin : g_unused
      assign tw_cos[g] = '0;
      assign tw_sin[g] = '0;
    end else if (4 * g > POINTS) begin : g_neg
      assign tw_cos[g] = -signed'(cos_q15(TH));
      assign tw_sin[g] = signed'(sin_q15(TH));
    end else begin : g_pos
      assign tw_cos[g] = signed'(cos_q15(TH));
      assign tw_sin[g] = signed'(sin_q15(TH));
    end
  end

  logic [2*DW-1:0] mem [POINTS];

  logic [1:0]    state_q, state_d;
  logic [2:0]    ph_q, ph_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [SW-1:0] st_q, st_d;
  logic [AW:0]   load_q, load_d;
  logic [2:0]    size_q;
  logic          inv_q;

  logic [2*DW-1:0]       rd_a_q, rd_b_q;
  logic signed [PW-1:0]  p_q, acc_q;
  logic signed [DW-1:0]  vr_q, vi_q;
  logic                  strobe_q;
  logic                  last_q;
  logic signed [OUT_BITS-1:0] res_re_q, res_im_q;

  logic          re, we;
  logic [AW-1:0] addr_a, addr_b, waddr;
  logic [2*DW-1:0] wdata;

  logic [SW-1:0] lg;
  logic [AW-1:0] nmask, low, half, rev_full, rev_j, pa, qa, kidx, gidx;
  logic [AW:0]   n_full, load_next;

  always_comb begin
    if (32'(size_q) > LG) begin
      lg = SW'(LG);
    end else begin
      lg = SW'(size_q);
    end
  end

  assign n_full = (AW + 1)'(1) << lg;
  assign nmask  = ~({AW{1'b1}} << lg);
  assign low    = AW'(({AW{1'b1}} << st_q) ^ {AW{1'b1}}) >> 1;
  assign half   = low + AW'(1);
  assign pa     = ((cnt_q & ~low) << 1) | (cnt_q & low);
  assign qa     = pa | half;
  assign kidx   = cnt_q & low;
  assign gidx   = kidx << (SW'(LG) - st_q);

  always_comb begin
    for (int b = 0; b < AW; b++) begin
      rev_full[b] = cnt_q[AW-1-b];
    end
  end
  assign rev_j     = rev_full >> (SW'(AW) - lg);
  assign load_next = load_q + (AW + 1)'(1);

  // Butterfly datapath.
  logic signed [DW-1:0]      ur, ui, xr, xi, mul_a;
  logic signed [TW_BITS-1:0] wr, wi, mul_b;
  logic signed [PW-1:0]      prod;
  logic signed [PW:0]        dsum;

  assign ur = rd_a_q[DW-1:0];
  assign ui = rd_a_q[2*DW-1:DW];
  assign xr = rd_b_q[DW-1:0];
  assign xi = rd_b_q[2*DW-1:DW];
  assign wr = tw_cos[gidx];
  assign wi = inv_q ? tw_sin[gidx] : -tw_sin[gidx];

  assign mul_a = (ph_q == 3'd1 || ph_q == 3'd3) ? xr : xi;
  assign mul_b = (ph_q == 3'd1 || ph_q == 3'd4) ? wr : wi;
  assign prod  = mul_a * mul_b;
  assign dsum  = (ph_q == 3'd3) ? (acc_q - p_q) : (acc_q + p_q);

  // Output scaling and saturation.
  logic signed [DW:0]   off, sre, sim;
  logic signed [EW-1:0] ere, eim;

  assign off = (DW + 1)'(((DW + 1)'(1) << lg) >> 1);
  assign sre = ((DW + 1)'(ur) + off) >>> lg;
  assign sim = ((DW + 1)'(ui) + off) >>> lg;
  assign ere = EW'(sre);
  assign eim = EW'(sim);

  function automatic logic signed [OUT_BITS-1:0] sat(input logic signed [EW-1:0] v);
    if (v > OUT_MAX) begin
      return OUT_MAX[OUT_BITS-1:0];
    end else if (v < OUT_MIN) begin
      return OUT_MIN[OUT_BITS-1:0];
    end
    return v[OUT_BITS-1:0];
  endfunction

  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    cnt_d   = cnt_q;
    st_d    = st_q;
    load_d  = load_q;
    re      = 1'b0;
    we      = 1'b0;
    addr_a  = cnt_q;
    addr_b  = cnt_q;
    waddr   = cnt_q;
    wdata   = rd_a_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          we     = 1'b1;
          waddr  = load_q[AW-1:0];
          wdata  = {DW'(sample_im_i), DW'(sample_re_i)};
          if (load_next >= n_full) begin
            load_d  = '0;
            state_d = S_REV;
            cnt_d   = '0;
            ph_d    = '0;
          end else begin
            load_d = load_next;
          end
        end
      end
      S_REV: begin
        addr_a = cnt_q;
        addr_b = rev_j;
        unique case (ph_q)
          3'd0: begin
            re = 1'b1;
            if (cnt_q < rev_j) begin
              ph_d = 3'd1;
            end
          end
          3'd1: begin
            we    = 1'b1;
            waddr = cnt_q;
            wdata = rd_b_q;
            ph_d  = 3'd2;
          end
          default: begin
            we    = 1'b1;
            waddr = rev_j;
            wdata = rd_a_q;
            ph_d  = 3'd0;
          end
        endcase
        if ((ph_q == 3'd0 && !(cnt_q < rev_j)) || ph_q == 3'd2) begin
          ph_d = 3'd0;
          if (cnt_q == nmask) begin
            cnt_d = '0;
            st_d  = SW'(1);
            if (lg == '0) begin
              state_d = S_OUT;
            end else begin
              state_d = S_BFLY;
            end
          end else begin
            cnt_d = cnt_q + AW'(1);
          end
        end
      end
      S_BFLY: begin
        addr_a = pa;
        addr_b = qa;
        ph_d   = ph_q + 3'd1;
        unique case (ph_q)
          3'd0: re = 1'b1;
          3'd6: begin
            we    = 1'b1;
            waddr = pa;
            wdata = {DW'(ui + vi_q), DW'(ur + vr_q)};
          end
          3'd7: begin
            we    = 1'b1;
            waddr = qa;
            wdata = {DW'(ui - vi_q), DW'(ur - vr_q)};
            if (cnt_q == (nmask >> 1)) begin
              cnt_d = '0;
              if (st_q == lg) begin
                state_d = S_OUT;
              end else begin
                st_d = st_q + SW'(1);
              end
            end else begin
              cnt_d = cnt_q + AW'(1);
            end
          end
          default: ;
        endcase
      end
      default: begin
        addr_a = cnt_q;
        if (ph_q == 3'd0) begin
          re   = 1'b1;
          ph_d = 3'd1;
        end else begin
          ph_d = 3'd0;
          if (cnt_q == nmask) begin
            state_d = S_IDLE;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_q + AW'(1);
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ph_q     <= '0;
      cnt_q    <= '0;
      st_q     <= '0;
      load_q   <= '0;
      size_q   <= 3'(LG > 6 ? 6 : LG);
      inv_q    <= 1'b0;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      ph_q     <= ph_d;
      cnt_q    <= cnt_d;
      st_q     <= st_d;
      load_q   <= load_d;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
      if (state_q == S_OUT && ph_q == 3'd1) begin
        strobe_q <= 1'b1;
        last_q   <= (cnt_q == nmask);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_SIZE: size_q <= cfg_data_i;
          CFG_INV:  inv_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_a_q <= mem[addr_a];
      rd_b_q <= mem[addr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= prod;
    if (ph_q == 3'd2 || ph_q == 3'd4) begin
      acc_q <= p_q;
    end
    if (state_q == S_BFLY && ph_q == 3'd3) begin
      vr_q <= DW'((dsum + RND_HALF) >>> 15);
    end
    if (state_q == S_BFLY && ph_q == 3'd5) begin
      vi_q <= DW'((dsum + RND_HALF) >>> 15);
    end
    if (state_q == S_OUT && ph_q == 3'd1) begin
      res_re_q <= inv_q ? sat(ere) : sat(EW'(ur));
      res_im_q <= inv_q ? sat(eim) : sat(EW'(ui));
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign cfg_ready_o    = (state_q == S_IDLE);
  assign result_valid_o = strobe_q;
  assign result_re_o    = res_re_q;
  assign result_im_o    = res_im_q;
  assign last_result_o  = last_q;

`ifndef SYNTHESIS
  a_last_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_result_o |-> result_valid_o)
    else $error("last flag without a result strobe");

  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("results closer than two cycles apart");

  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("transform began without a sample request");

  a_no_write_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |-> !we)
    else $error("frame store written during readout");
`endif

endmodule
